// ----- hw/rtl/spfr_pkg.sv -----
// Shared constants, types and the header table of the provisioning frame receiver.
`timescale 1ns / 1ps
`default_nettype none
package spfr_pkg;

	// item commands
	localparam logic CMD_BYTE = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	// result outcomes
	localparam logic [2:0] OUT_DATA    = 3'd0;
	localparam logic [2:0] OUT_GOOD    = 3'd1;
	localparam logic [2:0] OUT_BADSUM  = 3'd2;
	localparam logic [2:0] OUT_BADVER  = 3'd3;
	localparam logic [2:0] OUT_TIMEOUT = 3'd4;

	// configuration register indexes
	localparam int unsigned CFG_INDEX_W = 2;
	localparam int unsigned CFG_DATA_W  = 16;
	localparam logic [CFG_INDEX_W-1:0] CFG_HDR_TIMEOUT = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_PAY_TIMEOUT = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_VERSION     = 2'd2;

	localparam logic [15:0] HDR_TIMEOUT_RST = 16'd50;
	localparam logic [15:0] PAY_TIMEOUT_RST = 16'd100;
	localparam logic [7:0]  VERSION_RST     = 8'd1;

	localparam logic [7:0] START_BYTE = 8'h49; // 'I'

	typedef struct packed {
		logic [15:0] hdr_timeout;
		logic [15:0] pay_timeout;
		logic [7:0]  version;
	} spfr_cfg_t;

	typedef struct packed {
		logic       valid;
		logic [2:0] outcome;
		logic [7:0] data_byte;
		logic [7:0] packet_type;
		logic [7:0] payload_length;
	} spfr_result_t;

	// Remaining header characters after the start byte: "MPROV".
	function automatic logic [7:0] hdr_char(input logic [2:0] idx);
		logic [7:0] c;
		case (idx)
			3'd0: c = 8'h4D;
			3'd1: c = 8'h50;
			3'd2: c = 8'h52;
			3'd3: c = 8'h4F;
			3'd4: c = 8'h56;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/spfr_ifs.sv -----
// Valid/ready channel interfaces for receiver items and results.
`timescale 1ns / 1ps
`default_nettype none
interface spfr_item_if;
	logic       valid;
	logic       ready;
	logic       command;
	logic [7:0] rx_byte;

	modport source (output valid, output command, output rx_byte, input ready);
	modport sink (input valid, input command, input rx_byte, output ready);
endinterface

interface spfr_result_if;
	logic       valid;
	logic       ready;
	logic [2:0] outcome;
	logic [7:0] data_byte;
	logic [7:0] packet_type;
	logic [7:0] payload_length;

	modport source (output valid, output outcome, output data_byte, output packet_type,
		output payload_length, input ready);
	modport sink (input valid, input outcome, input data_byte, input packet_type,
		input payload_length, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/spfr_parser.sv -----
// Frame parsing state and per-item result logic.
`timescale 1ns / 1ps
`default_nettype none
module spfr_parser
	import spfr_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         step,
	input  wire logic         item_valid,
	input  wire logic         command,
	input  wire logic [7:0]   rx_byte,
	input  wire spfr_cfg_t    cfg,
	output spfr_result_t      res
);

	localparam logic [2:0] PH_HUNT    = 3'd0;
	localparam logic [2:0] PH_HDR     = 3'd1;
	localparam logic [2:0] PH_FIELDS  = 3'd2;
	localparam logic [2:0] PH_PAYLOAD = 3'd3;
	localparam logic [2:0] PH_CHECK   = 3'd4;

	logic [2:0]  phase_q, phase_d;
	logic [7:0]  byte_count_q, byte_count_d;
	logic        mismatch_q, mismatch_d;
	logic [7:0]  type_q, type_d;
	logic [7:0]  length_q, length_d;
	logic [7:0]  sum_q, sum_d;
	logic [15:0] tick_q, tick_d;
	logic [7:0]  version_q, version_d;

	logic [15:0] tick_inc;
	logic [15:0] limit;
	logic [7:0]  count_inc;
	logic [7:0]  sum_add;
	logic [7:0]  ver_now;
	logic        emit;
	logic [2:0]  outcome;
	logic [7:0]  data;

	assign tick_inc  = (tick_q == 16'hFFFF) ? tick_q : tick_q + 16'd1;
	assign limit     = (phase_q == PH_PAYLOAD) ? cfg.pay_timeout : cfg.hdr_timeout;
	assign count_inc = byte_count_q + 8'd1;
	assign sum_add   = sum_q + rx_byte;
	assign ver_now   = (byte_count_q == 8'd0) ? rx_byte : version_q;

	always_comb begin
		phase_d      = phase_q;
		byte_count_d = byte_count_q;
		mismatch_d   = mismatch_q;
		type_d       = type_q;
		length_d     = length_q;
		sum_d        = sum_q;
		tick_d       = tick_q;
		version_d    = version_q;
		emit         = 1'b0;
		outcome      = OUT_DATA;
		data         = 8'd0;

		if (command == CMD_TICK) begin
			if (phase_q != PH_HUNT && phase_q <= PH_CHECK) begin
				tick_d = tick_inc;
				if (tick_inc >= limit) begin
					phase_d      = PH_HUNT;
					byte_count_d = 8'd0;
					tick_d       = 16'd0;
					// header rest timeout is silent: no frame yet
					if (phase_q != PH_HDR) begin
						emit    = 1'b1;
						outcome = OUT_TIMEOUT;
					end
				end
			end
		end else begin
			case (phase_q)
				PH_HDR: begin
					if (rx_byte != hdr_char(byte_count_q[2:0]))
						mismatch_d = 1'b1;
					byte_count_d = count_inc;
					if (byte_count_q == 8'd4) begin
						byte_count_d = 8'd0;
						tick_d       = 16'd0;
						if (mismatch_d) begin
							phase_d = PH_HUNT;
						end else begin
							phase_d   = PH_FIELDS;
							type_d    = 8'd0;
							length_d  = 8'd0;
							sum_d     = 8'd0;
							version_d = 8'd0;
						end
					end
				end
				PH_FIELDS: begin
					sum_d        = sum_add;
					byte_count_d = count_inc;
					if (byte_count_q == 8'd0)
						version_d = rx_byte;
					else if (byte_count_q == 8'd1)
						type_d = rx_byte;
					else
						length_d = rx_byte;
					if (byte_count_q >= 8'd2) begin
						byte_count_d = 8'd0;
						tick_d       = 16'd0;
						if (ver_now != cfg.version) begin
							phase_d = PH_HUNT;
							emit    = 1'b1;
							outcome = OUT_BADVER;
						end else begin
							phase_d = (length_d == 8'd0) ? PH_CHECK : PH_PAYLOAD;
						end
					end
				end
				PH_PAYLOAD: begin
					sum_d        = sum_add;
					byte_count_d = count_inc;
					emit         = 1'b1;
					outcome      = OUT_DATA;
					data         = rx_byte;
					if ({1'b0, byte_count_q} + 9'd1 >= {1'b0, length_q}) begin
						phase_d      = PH_CHECK;
						byte_count_d = 8'd0;
						tick_d       = 16'd0;
					end
				end
				PH_CHECK: begin
					phase_d      = PH_HUNT;
					byte_count_d = 8'd0;
					tick_d       = 16'd0;
					emit         = 1'b1;
					outcome      = (rx_byte == sum_q) ? OUT_GOOD : OUT_BADSUM;
				end
				default: begin
					// hunting, and any stray code
					phase_d = PH_HUNT;
					if (rx_byte == START_BYTE) begin
						phase_d      = PH_HDR;
						byte_count_d = 8'd0;
						tick_d       = 16'd0;
						mismatch_d   = 1'b0;
					end
				end
			endcase
		end
	end

	always_comb begin
		res.valid          = item_valid && emit;
		res.outcome        = outcome;
		res.data_byte      = data;
		res.packet_type    = type_d;
		res.payload_length = length_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_HUNT;
			byte_count_q <= 8'd0;
			mismatch_q   <= 1'b0;
			type_q       <= 8'd0;
			length_q     <= 8'd0;
			sum_q        <= 8'd0;
			tick_q       <= 16'd0;
			version_q    <= 8'd0;
		end else if (step) begin
			phase_q      <= phase_d;
			byte_count_q <= byte_count_d;
			mismatch_q   <= mismatch_d;
			type_q       <= type_d;
			length_q     <= length_d;
			sum_q        <= sum_d;
			tick_q       <= tick_d;
			version_q    <= version_d;
		end
	end

	a_hunt_tick_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_HUNT && command == CMD_TICK) |-> !emit)
		else $error("tick while hunting produced a result");

	a_data_in_payload: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.outcome == OUT_DATA) |-> phase_q == PH_PAYLOAD)
		else $error("payload byte forwarded outside payload phase");

	a_fields_count: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_FIELDS) |-> byte_count_q < 8'd3)
		else $error("field byte count overran");

	a_end_to_hunt: assert property (@(posedge clk) disable iff (!arst_n)
		(step && res.valid && res.outcome != OUT_DATA) |=> phase_q == PH_HUNT)
		else $error("frame ended without returning to hunt");

endmodule
`default_nettype wire

// ----- hw/rtl/spfr_out_stage.sv -----
// Result register that drives the result channel.
`timescale 1ns / 1ps
`default_nettype none
module spfr_out_stage
	import spfr_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       load,
	input  wire spfr_result_t res,
	output logic            can_take,
	spfr_result_if.source   result
);

	logic         valid_q;
	spfr_result_t data_q;

	assign can_take = !valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load && res.valid) begin
			valid_q <= 1'b1;
		end else if (result.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load && res.valid)
			data_q <= res;
	end

	assign result.valid          = valid_q;
	assign result.outcome        = data_q.outcome;
	assign result.data_byte      = data_q.data_byte;
	assign result.packet_type    = data_q.packet_type;
	assign result.payload_length = data_q.payload_length;

endmodule
`default_nettype wire

// ----- hw/rtl/serial_provisioning_frame_receiver.sv -----
// Top level of the serial provisioning frame receiver.
//
//  channel  dir  handshake      payload
//  item     in   valid/ready    command[0], rx_byte[7:0]
//  result   out  valid/ready    outcome[2:0], data_byte, packet_type, payload_length
//  config   in   cfg_we only    cfg_index[1:0], cfg_data[15:0]
//
// One item per cycle sustained: an accepted item is held in the input register,
// the parser updates its state from it and the result (if any) lands in the
// output register, which offers it on the result channel.
// The output register sets the rate under stall: while it holds an untaken result
// the item in the input register waits and the input channel stalls.
// Reset (arst_n low) clears the parser state, the channel valids and loads the
// register defaults; there is no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module serial_provisioning_frame_receiver
	import spfr_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_we,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data,
	spfr_item_if.sink                   item,
	spfr_result_if.source               result
);

	spfr_cfg_t    cfg_q;
	spfr_result_t res;

	logic       valid_s1;
	logic       command_s1;
	logic [7:0] rx_byte_s1;
	logic       can_take;
	logic       advance;

	// Hold register defaults after reset; take writes by index, drop unknown ones.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hdr_timeout <= HDR_TIMEOUT_RST;
			cfg_q.pay_timeout <= PAY_TIMEOUT_RST;
			cfg_q.version     <= VERSION_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_HDR_TIMEOUT: cfg_q.hdr_timeout <= cfg_data;
				CFG_PAY_TIMEOUT: cfg_q.pay_timeout <= cfg_data;
				CFG_VERSION:     cfg_q.version     <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// Advance the held item once the output register has room for its result.
	assign advance    = valid_s1 && can_take;
	assign item.ready = !valid_s1 || can_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			command_s1 <= item.command;
			rx_byte_s1 <= item.rx_byte;
		end
	end

	spfr_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.item_valid (valid_s1),
		.command    (command_s1),
		.rx_byte    (rx_byte_s1),
		.cfg        (cfg_q),
		.res        (res)
	);

	spfr_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance),
		.res      (res),
		.can_take (can_take),
		.result   (result)
	);

endmodule
`default_nettype wire
